### design/bsd_pkg.sv
// Shared types, status codes and the character decode table for the Base64
// stream decoder. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package bsd_pkg;

   localparam logic [1:0] STATUS_DATA    = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHR = 2'd1;
   localparam logic [1:0] STATUS_BAD_PAD = 2'd2;
   localparam logic [1:0] STATUS_BAD_LEN = 2'd3;

   // Sextet codes above the alphabet
   localparam logic [6:0] SX_BAD = 7'd64;
   localparam logic [6:0] SX_PAD = 7'd65;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // One queued job: up to three bytes, or one error result
   typedef struct packed {
      logic [23:0] triple;
      logic [1:0]  count;    // 1..3 results
      logic [1:0]  status;
      logic        fin;      // message ends with this job
   } job_type;

   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] sx;
      sx = SX_BAD;
      if (c inside {[8'd65 : 8'd90]}) begin
         sx = 7'(c - 8'd65);
      end else if (c inside {[8'd97 : 8'd122]}) begin
         sx = 7'(c - 8'd71);
      end else if (c inside {[8'd48 : 8'd57]}) begin
         sx = 7'(c + 8'd4);
      end else if (c == 8'd43) begin
         sx = 7'd62;
      end else if (c == 8'd47) begin
         sx = 7'd63;
      end else if (c == 8'd61) begin
         sx = SX_PAD;
      end
      return sx;
   endfunction

endpackage

### design/base64_stream_decoder.sv
// Top level of the Base64 stream decoder: front end, job queue, back end.
// Depends on bsd_pkg, bsd_front, bsd_queue and bsd_back.
//
//   channel  dir  tdata            tuser                     tlast
//   req_     in   [7:0] char_code  -                         final_char
//   rsp_     out  [7:0] data_byte  [1:0] status, [2] run_end message_end
//
// One character accepted per cycle while the four-entry job queue has room.
// Each full group or error becomes one job; the back end sends one result word
// per cycle while the output is accepted, so a three-byte group gives three words.
// A job is registered in the queue entry and then in the output register.
// Reset (synchronous) clears group state, queue pointers and fill count, and output valid.
`timescale 1ns / 1ps

module base64_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // final_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic [2:0] rsp_tuser,   // [1:0] status, [2] run_end
   output logic       rsp_tlast    // message_end
);

   logic             accept;
   logic             job_push;
   bsd_pkg::job_type job;
   logic             full;
   logic             head_valid;
   bsd_pkg::job_type head_job;
   logic             pop;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   bsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_code  (req_tdata),
      .final_char (req_tlast),
      .job_push   (job_push),
      .job        (job)
   );

   bsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (job),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   bsd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_data_byte   (rsp_tdata),
      .rsp_status      (rsp_tuser[1:0]),
      .rsp_run_end     (rsp_tuser[2]),
      .rsp_message_end (rsp_tlast)
   );

endmodule

### design/bsd_front.sv
// Front end of the Base64 stream decoder: accepts characters, tracks the
// group position and held sextets, and issues byte or error jobs. Uses bsd_pkg.
`timescale 1ns / 1ps

module bsd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       char_code,
   input  logic             final_char,
   output logic             job_push,
   output bsd_pkg::job_type job
);

   logic [1:0]  slot_ff,     slot_in;
   logic [17:0] held_ff,     held_in;
   logic        two_pad_ff,  two_pad_in;
   logic        dropping_ff, dropping_in;

   logic [6:0] sx;
   logic       is_bad, is_pad;

   always_comb begin
      sx     = bsd_pkg::sextet_of(char_code);
      is_bad = (sx == bsd_pkg::SX_BAD);
      is_pad = (sx == bsd_pkg::SX_PAD);

      slot_in     = slot_ff;
      held_in     = held_ff;
      two_pad_in  = two_pad_ff;
      dropping_in = dropping_ff;
      job_push    = 1'b0;
      job.triple  = 24'd0;
      job.count   = 2'd1;
      job.status  = bsd_pkg::STATUS_DATA;
      job.fin     = 1'b1;

      if (dropping_ff) begin
         if (final_char) begin
            dropping_in = 1'b0;
            slot_in     = 2'd0;
            held_in     = 18'd0;
            two_pad_in  = 1'b0;
         end
      end else begin
         if (is_bad) begin
            job_push   = 1'b1;
            job.status = bsd_pkg::STATUS_BAD_CHR;
         end else if (slot_ff < 2'd2) begin
            if (is_pad) begin
               job_push   = 1'b1;
               job.status = bsd_pkg::STATUS_BAD_PAD;
            end else if (final_char) begin
               job_push   = 1'b1;
               job.status = bsd_pkg::STATUS_BAD_LEN;
            end else begin
               held_in = {held_ff[11:0], sx[5:0]};
               slot_in = slot_ff + 2'd1;
            end
         end else if (slot_ff == 2'd2) begin
            if (final_char) begin
               job_push   = 1'b1;
               job.status = bsd_pkg::STATUS_BAD_LEN;
            end else begin
               two_pad_in = is_pad;
               held_in    = {held_ff[11:0], (is_pad ? 6'd0 : sx[5:0])};
               slot_in    = 2'd3;
            end
         end else begin
            if ((two_pad_ff && !is_pad) || (is_pad && !final_char)) begin
               job_push   = 1'b1;
               job.status = bsd_pkg::STATUS_BAD_PAD;
            end else begin
               job_push   = 1'b1;
               job.triple = {held_ff, (is_pad ? 6'd0 : sx[5:0])};
               job.count  = two_pad_ff ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
               job.fin    = final_char;
            end
         end

         // Any job ends the group; an error also drops the rest of the message
         if (job_push) begin
            slot_in    = 2'd0;
            held_in    = 18'd0;
            two_pad_in = 1'b0;
            if (job.status != bsd_pkg::STATUS_DATA) begin
               dropping_in = !final_char;
            end
         end
      end

      job_push = job_push && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= 2'd0;
         held_ff     <= 18'd0;
         two_pad_ff  <= 1'b0;
         dropping_ff <= 1'b0;
      end else if (accept) begin
         slot_ff     <= slot_in;
         held_ff     <= held_in;
         two_pad_ff  <= two_pad_in;
         dropping_ff <= dropping_in;
      end
   end

endmodule

### design/bsd_queue.sv
// Short job queue between front and back end of the Base64 stream decoder.
// Register-based FIFO of bsd_pkg::job_type entries; uses bsd_pkg.
`timescale 1ns / 1ps

module bsd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bsd_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output bsd_pkg::job_type head_job
);

   bsd_pkg::job_type entry_ff [bsd_pkg::QUEUE_DEPTH];

   logic [bsd_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bsd_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bsd_pkg::QUEUE_AW:0]   fill_ff,   fill_in;

   always_comb begin
      full       = (fill_ff == (bsd_pkg::QUEUE_AW+1)'(bsd_pkg::QUEUE_DEPTH));
      head_valid = (fill_ff != '0);
      head_job   = entry_ff[rd_ptr_ff];
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in    = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### design/bsd_back.sv
// Back end of the Base64 stream decoder: splits each queued job into result
// words and holds them in an output register. Uses bsd_pkg.
`timescale 1ns / 1ps

module bsd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  bsd_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_data_byte,
   output logic [1:0]       rsp_status,
   output logic             rsp_run_end,
   output logic             rsp_message_end
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] status_ff;
   logic       run_end_ff, run_end_in;
   logic       msg_end_ff;
   logic       load;

   always_comb begin
      load       = head_valid && (!valid_ff || rsp_tready);
      run_end_in = (idx_ff == head_job.count - 2'd1);
      pop        = load && run_end_in;
      case (idx_ff)
         2'd0:    byte_in = head_job.triple[23:16];
         2'd1:    byte_in = head_job.triple[15:8];
         default: byte_in = head_job.triple[7:0];
      endcase
      idx_in = idx_ff;
      if (load) begin
         idx_in = run_end_in ? 2'd0 : idx_ff + 2'd1;
      end
      valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff    <= byte_in;
         status_ff  <= head_job.status;
         run_end_ff <= run_end_in;
         msg_end_ff <= run_end_in && head_job.fin;
      end
   end

   assign rsp_tvalid      = valid_ff;
   assign rsp_data_byte   = byte_ff;
   assign rsp_status      = status_ff;
   assign rsp_run_end     = run_end_ff;
   assign rsp_message_end = msg_end_ff;

endmodule
